// ----- hw/rtl/dpnc_pkg.sv -----
// Shared types and constants for the DAC palette nearest-color unit.
`default_nettype none
package dpnc_pkg;

  localparam int unsigned CompW = 6;
  localparam int unsigned EntryW = 8;
  localparam int unsigned ColorW = 4;
  localparam int unsigned NumFixed = 16;
  localparam int unsigned DistW = 14;

  typedef enum logic [2:0] {
    PhRed   = 3'b001,
    PhGreen = 3'b010,
    PhBlue  = 3'b100
  } phase_e;

  typedef enum logic {
    KindIndex = 1'b0,
    KindData  = 1'b1
  } kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [EntryW-1:0] entry;
    logic [ColorW-1:0] color;
  } out_t;

  typedef struct packed {
    logic [EntryW-1:0] entry;
    logic [CompW-1:0]  red;
    logic [CompW-1:0]  green;
    logic [CompW-1:0]  blue;
  } job_t;

  localparam logic [CompW-1:0] FixedRgb [NumFixed*3] = '{
    6'd0,  6'd0,  6'd0,   6'd0,  6'd0,  6'd42,  6'd0,  6'd42, 6'd0,   6'd0,  6'd42, 6'd42,
    6'd42, 6'd0,  6'd0,   6'd42, 6'd0,  6'd42,  6'd42, 6'd21, 6'd0,   6'd42, 6'd42, 6'd42,
    6'd21, 6'd21, 6'd21,  6'd21, 6'd21, 6'd63,  6'd21, 6'd63, 6'd21,  6'd21, 6'd63, 6'd63,
    6'd63, 6'd21, 6'd21,  6'd63, 6'd21, 6'd63,  6'd63, 6'd63, 6'd21,  6'd63, 6'd63, 6'd63
  };

endpackage
`default_nettype wire

// ----- hw/rtl/dpnc_front.sv -----
// Front end: tracks the entry pointer and component phase and issues completed triples.
`default_nettype none
module dpnc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dpnc_pkg::in_t in_data_i,
  output logic               push_o,
  output dpnc_pkg::job_t     job_o,
  input  wire logic          full_i
);

  dpnc_pkg::phase_e              phase_q, phase_d;
  logic [dpnc_pkg::EntryW-1:0]   ptr_q, ptr_d;
  logic [dpnc_pkg::CompW-1:0]    red_q, red_d, green_q, green_d;
  logic                          accept;
  logic [dpnc_pkg::CompW-1:0]    comp;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign comp       = in_data_i.value[dpnc_pkg::CompW-1:0];

  always_comb begin
    phase_d = phase_q;
    ptr_d   = ptr_q;
    red_d   = red_q;
    green_d = green_q;
    push_o  = 1'b0;
    if (accept) begin
      if (in_data_i.kind == dpnc_pkg::KindIndex) begin
        ptr_d   = in_data_i.value;
        phase_d = dpnc_pkg::PhRed;
      end else begin
        case (phase_q)
          dpnc_pkg::PhRed: begin
            red_d   = comp;
            phase_d = dpnc_pkg::PhGreen;
          end
          dpnc_pkg::PhGreen: begin
            green_d = comp;
            phase_d = dpnc_pkg::PhBlue;
          end
          default: begin
            push_o  = 1'b1;
            ptr_d   = ptr_q + 1'b1;
            phase_d = dpnc_pkg::PhRed;
          end
        endcase
      end
    end
  end

  assign job_o = '{entry: ptr_q, red: red_q, green: green_q, blue: comp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dpnc_pkg::PhRed;
      ptr_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (phase_q == dpnc_pkg::PhRed) && (ptr_q == $past(ptr_q) + 1'b1))
    else $error("Completed triple did not advance the entry pointer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept && in_data_i.kind == dpnc_pkg::KindData)
    else $error("Triple issued without a data-port transaction.");

endmodule
`default_nettype wire

// ----- hw/rtl/dpnc_fifo.sv -----
// Small job queue between the front end and the distance pipeline.
`default_nettype none
module dpnc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dpnc_pkg::job_t job_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output dpnc_pkg::job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dpnc_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Push into a full queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("Queue fill count exceeds its depth.");

endmodule
`default_nettype wire

// ----- hw/rtl/dpnc_back.sv -----
// Back end: squared-distance search over the 16 fixed colors, three pipeline stages.
`default_nettype none
module dpnc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire dpnc_pkg::job_t job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dpnc_pkg::out_t      out_data_o
);

  localparam int unsigned NumGroups = 4;
  localparam int unsigned GroupSize = dpnc_pkg::NumFixed / NumGroups;

  logic                        en;
  logic [dpnc_pkg::DistW-1:0]  dist_d [dpnc_pkg::NumFixed];
  logic [dpnc_pkg::DistW-1:0]  dist_q [dpnc_pkg::NumFixed];
  logic [dpnc_pkg::EntryW-1:0] a_entry_q, b_entry_q;
  logic                        a_valid_q, b_valid_q, out_valid_q;
  logic [dpnc_pkg::DistW-1:0]  gdist_d [NumGroups];
  logic [dpnc_pkg::DistW-1:0]  gdist_q [NumGroups];
  logic [dpnc_pkg::ColorW-1:0] gidx_d [NumGroups];
  logic [dpnc_pkg::ColorW-1:0] gidx_q [NumGroups];
  logic [dpnc_pkg::ColorW-1:0] fidx;
  logic [dpnc_pkg::DistW-1:0]  fdist;
  dpnc_pkg::out_t              out_q;

  function automatic logic [11:0] sq_diff(logic [5:0] a, logic [5:0] b);
    logic [5:0] d;
    d = (a > b) ? a - b : b - a;
    return 12'(d * d);
  endfunction

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int i = 0; i < dpnc_pkg::NumFixed; i++) begin
      dist_d[i] = dpnc_pkg::DistW'(sq_diff(job_i.red,   dpnc_pkg::FixedRgb[3*i]))
                + dpnc_pkg::DistW'(sq_diff(job_i.green, dpnc_pkg::FixedRgb[3*i+1]))
                + dpnc_pkg::DistW'(sq_diff(job_i.blue,  dpnc_pkg::FixedRgb[3*i+2]));
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      gdist_d[g] = dist_q[g*GroupSize];
      gidx_d[g]  = dpnc_pkg::ColorW'(g*GroupSize);
      for (int k = 1; k < GroupSize; k++) begin
        if (dist_q[g*GroupSize+k] < gdist_d[g]) begin
          gdist_d[g] = dist_q[g*GroupSize+k];
          gidx_d[g]  = dpnc_pkg::ColorW'(g*GroupSize+k);
        end
      end
    end
  end

  always_comb begin
    fdist = gdist_q[0];
    fidx  = gidx_q[0];
    for (int g = 1; g < NumGroups; g++) begin
      if (gdist_q[g] < fdist) begin
        fdist = gdist_q[g];
        fidx  = gidx_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q    <= dist_d;
      a_entry_q <= job_i.entry;
      gdist_q   <= gdist_d;
      gidx_q    <= gidx_d;
      b_entry_q <= a_entry_q;
      out_q     <= '{entry: b_entry_q, color: fidx};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= job_valid_i;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && en) |=> b_valid_q && (b_entry_q == $past(a_entry_q)))
    else $error("Job lost between distance and group stages.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(a_valid_q) && $stable(b_valid_q))
    else $error("Pipeline moved while the output was stalled.");

endmodule
`default_nettype wire

// ----- hw/rtl/dac_palette_nearest_color_unit.sv -----
// Top level of the DAC palette write port with nearest-color mapping.
// The input channel carries one port write per transaction: kind selects the
// index port or the data port, and value is the written byte. An index write
// points at the red component of that entry. Data writes store red, then
// green, then blue; the blue write completes the triple and the entry pointer
// advances, wrapping after entry 255.
// Each completed triple yields one output transaction with the entry number
// and the nearest of the 16 fixed colors by squared RGB distance, the lowest
// color winning a tie. Other writes yield nothing.
// A new write is taken every cycle while the queue is not full. A blue write's
// job goes through the queue, then stages that compute the 16 distances,
// reduce them to four group minima, and register the winner at the output.
// When the receiver stalls, the pipeline holds and the job queue fills; input
// ready drops only once the queue is full.
// Reset clears the pointer to entry 0, the phase to red, the held components
// to zero, and empties the queue and the pipeline.
`default_nettype none
module dac_palette_nearest_color_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dpnc_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dpnc_pkg::out_t      out_data_o
);

  logic           push, full, q_valid, pop;
  dpnc_pkg::job_t push_job, q_job;

  dpnc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  dpnc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (q_job)
  );

  dpnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
